/* design/esud_pkg.sv */
// shared types, character codes and sizes for the escaped string decoder
package esud_pkg;

    // widest burst one raw word can cause: backslash, U, seven digits, bad byte
    localparam int RUN_MAX  = 10;
    localparam int RUN_CW   = $clog2(RUN_MAX + 1);
    localparam int DIG_MAX  = 8;
    localparam int DIG_W    = $clog2(DIG_MAX);
    localparam int SEEN_W   = 4;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_V  = 8'h76;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_UP_U  = 8'h55;

    localparam logic [7:0] CTL_LF   = 8'h0A;
    localparam logic [7:0] CTL_CR   = 8'h0D;
    localparam logic [7:0] CTL_TAB  = 8'h09;
    localparam logic [7:0] CTL_BEL  = 8'h07;
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_VT   = 8'h0B;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
    } out_word_t;

    // the bytes one raw word expands to, plus the string end mark
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CW-1:0]       count;
        logic                    last;
    } run_t;

endpackage

/* design/esud_front.sv */
// front end: escape and hex run decoding, one raw word per cycle while take is high, into a byte run
module esud_front
    import esud_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    output run_t     run
);

    mode_t             mode_reg, mode_next;
    logic              wide_reg, wide_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [31:0]       cv_reg, cv_next;
    logic [15:0]       pend_reg, pend_next;
    logic [7:0]        held_reg [DIG_MAX];
    logic [7:0]        held_eff [DIG_MAX];

    logic [7:0]        b;
    logic              fin;
    logic              dig_ok;
    logic [3:0]        dig_val;
    logic              hold_we;
    logic [SEEN_W-1:0] need;
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W-1:0] nd;
    logic [RUN_CW-1:0] flush_cnt;
    logic              tail;
    logic [31:0]       cp_raw;
    logic [31:0]       cp;
    logic              is_high;
    logic              is_low;
    logic              pair;
    logic [3:0][7:0]   u8_bytes;
    logic [RUN_CW-1:0] u8_cnt;

    assign b        = word.in_byte;
    assign fin      = word.string_end;
    assign need     = wide_reg ? SEEN_W'(8) : SEEN_W'(4);
    assign seen_inc = seen_reg + SEEN_W'(1);
    assign hold_we  = (mode_reg == MODE_HEX) && dig_ok;
    assign nd       = dig_ok ? seen_inc : seen_reg;
    assign flush_cnt = RUN_CW'(2) + RUN_CW'(nd);
    assign tail     = !dig_ok && !((b == CH_BSL) && !fin);

    always_comb
    begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        priority if (b >= 8'h30 && b <= 8'h39)
            dig_val = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66)
            dig_val = 4'(b - 8'h61 + 8'd10);
        else if (b >= 8'h41 && b <= 8'h46)
            dig_val = 4'(b - 8'h41 + 8'd10);
        else
            dig_ok = 1'b0;
    end

    always_comb
    begin
        for (int k = 0; k < DIG_MAX; k++)
        begin
            held_eff[k] = (hold_we && (seen_reg[DIG_W-1:0] == DIG_W'(k))) ? b : held_reg[k];
        end
    end

    // code point of a completed run, surrogate pair folded in
    assign cp_raw  = {cv_reg[27:0], dig_val};
    assign is_high = (cp_raw >= 32'hD800) && (cp_raw <= 32'hDBFF);
    assign is_low  = (cp_raw >= 32'hDC00) && (cp_raw <= 32'hDFFF);
    assign pair    = is_low && (pend_reg != 16'd0);
    assign cp      = pair ? (32'h10000 + {12'd0, pend_reg[9:0], cp_raw[9:0]}) : cp_raw;

    always_comb
    begin
        u8_bytes = '0;
        u8_cnt   = '0;
        priority if (cp <= 32'h7F)
        begin
            u8_bytes[0] = cp[7:0];
            u8_cnt      = RUN_CW'(1);
        end
        else if (cp <= 32'h7FF)
        begin
            u8_bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
            u8_bytes[1] = 8'h80 | {2'd0, cp[5:0]};
            u8_cnt      = RUN_CW'(2);
        end
        else if (cp <= 32'hFFFF)
        begin
            u8_bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
            u8_bytes[1] = 8'h80 | {2'd0, cp[11:6]};
            u8_bytes[2] = 8'h80 | {2'd0, cp[5:0]};
            u8_cnt      = RUN_CW'(3);
        end
        else if (cp <= 32'h10FFFF)
        begin
            u8_bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
            u8_bytes[1] = 8'h80 | {2'd0, cp[17:12]};
            u8_bytes[2] = 8'h80 | {2'd0, cp[11:6]};
            u8_bytes[3] = 8'h80 | {2'd0, cp[5:0]};
            u8_cnt      = RUN_CW'(4);
        end
        else
        begin
            // above the unicode range nothing is written
            u8_cnt      = '0;
        end
    end

    // next mode
    always_comb
    begin
        mode_next = MODE_PLAIN;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (((b == CH_LO_U) || (b == CH_UP_U)) && !fin)
                    mode_next = MODE_HEX;
            end
            MODE_HEX:
            begin
                if (dig_ok && (seen_inc < need) && !fin)
                    mode_next = MODE_HEX;
                else if (!dig_ok && (b == CH_BSL) && !fin)
                    mode_next = MODE_ESC;
            end
            default:
            begin
                if ((b == CH_BSL) && !fin)
                    mode_next = MODE_ESC;
            end
        endcase
    end

    // emitted bytes and datapath updates
    always_comb
    begin
        run.bytes = '0;
        run.count = '0;
        run.last  = fin;
        wide_next = wide_reg;
        seen_next = seen_reg;
        cv_next   = cv_reg;
        pend_next = pend_reg;
        unique case (mode_reg)
            MODE_ESC:
            begin
                run.count = RUN_CW'(1);
                unique case (b)
                    CH_LO_N:  run.bytes[0] = CTL_LF;
                    CH_LO_R:  run.bytes[0] = CTL_CR;
                    CH_LO_T:  run.bytes[0] = CTL_TAB;
                    CH_LO_A:  run.bytes[0] = CTL_BEL;
                    CH_LO_B:  run.bytes[0] = CTL_BS;
                    CH_LO_F:  run.bytes[0] = CTL_FF;
                    CH_LO_V:  run.bytes[0] = CTL_VT;
                    CH_BSL:   run.bytes[0] = CH_BSL;
                    CH_QUOTE: run.bytes[0] = CH_QUOTE;
                    CH_LO_U, CH_UP_U:
                    begin
                        if (fin)
                        begin
                            run.bytes[0] = CH_BSL;
                            run.bytes[1] = b;
                            run.count    = RUN_CW'(2);
                        end
                        else
                        begin
                            run.count = '0;
                            wide_next = (b == CH_UP_U);
                            seen_next = '0;
                            cv_next   = '0;
                        end
                    end
                    default:
                    begin
                        run.bytes[0] = CH_BSL;
                        run.bytes[1] = b;
                        run.count    = RUN_CW'(2);
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (dig_ok)
                begin
                    seen_next = seen_inc;
                    cv_next   = cp_raw;
                end
                if (dig_ok && (seen_inc >= need))
                begin
                    // run complete: hold a high half, otherwise write utf-8
                    if (is_high)
                        pend_next = cp_raw[15:0];
                    else
                    begin
                        if (pair)
                            pend_next = 16'd0;
                        for (int k = 0; k < 4; k++)
                            run.bytes[k] = u8_bytes[k];
                        run.count = u8_cnt;
                    end
                end
                else if (!dig_ok || fin)
                begin
                    // pass the broken run through, then the bad byte unless it opens an escape
                    for (int k = 0; k < RUN_MAX; k++)
                    begin
                        if (k == 0)
                            run.bytes[k] = CH_BSL;
                        else if (k == 1)
                            run.bytes[k] = wide_reg ? CH_UP_U : CH_LO_U;
                        else if (SEEN_W'(k - 2) < nd)
                            run.bytes[k] = held_eff[DIG_W'(k - 2)];
                        else if (tail && (RUN_CW'(k) == flush_cnt))
                            run.bytes[k] = b;
                    end
                    run.count = flush_cnt + RUN_CW'(tail);
                end
            end
            default:
            begin
                if (!((b == CH_BSL) && !fin))
                begin
                    run.bytes[0] = b;
                    run.count    = RUN_CW'(1);
                end
            end
        endcase
        if (fin)
        begin
            wide_next = 1'b0;
            seen_next = '0;
            cv_next   = '0;
            pend_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            wide_reg <= 1'b0;
            seen_reg <= '0;
            cv_reg   <= '0;
            pend_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            wide_reg <= wide_next;
            seen_reg <= seen_next;
            cv_reg   <= cv_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hold_we)
            held_reg[seen_reg[DIG_W-1:0]] <= b;
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && fin) |=> (mode_reg == MODE_PLAIN) && (pend_reg == 16'd0)
                          && (seen_reg == '0))
        else $error("string end did not return the decoder to plain text");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HEX) |-> (seen_reg < need))
        else $error("hex run kept going past its digit count");

endmodule

/* design/esud_queue.sv */
// short run queue between the decoding front end and the byte sequencer
module esud_queue
    import esud_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t wr_run,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output run_t head_run
);

    run_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_run   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_run;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("run pushed into a full queue");

endmodule

/* design/esud_back.sv */
// back end: steps through the head run one byte per cycle, while the output is not stalled, into the output register
module esud_back
    import esud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  run_t      head_run,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    logic [RUN_CW-1:0] idx_reg, idx_next;
    logic              ov_reg, ov_next;
    out_word_t         ow_reg;
    logic              load;
    logic              is_last;
    logic              empty_run;

    assign empty_run = (head_run.count == '0);
    assign is_last   = empty_run || (idx_reg == head_run.count - RUN_CW'(1));
    assign load      = head_valid && (!ov_reg || !out_stall);
    assign pop       = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg && out_stall;
        if (load)
        begin
            ov_next  = 1'b1;
            idx_next = is_last ? '0 : idx_reg + RUN_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ow_reg.out_byte    <= empty_run ? 8'd0 : head_run.bytes[idx_reg];
            ow_reg.byte_valid  <= !empty_run;
            ow_reg.run_last    <= is_last;
            ow_reg.string_done <= is_last && head_run.last;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid && (idx_reg < head_run.count))
        else $error("byte index left over without a run at the head");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !ow_reg.byte_valid) |-> ow_reg.run_last && ow_reg.string_done)
        else $error("empty marker that does not close the string");

endmodule

/* design/escaped_string_utf8_decoder_unit.sv */
// top level of the escaped string decoder: front end, run queue, byte sequencer
//
//  channel  | valid      | stall      | word                       | dir
//  ---------+------------+------------+----------------------------+-----
//  raw      | raw_valid  | raw_stall  | raw_word  (in_word_t)      | in
//  text     | text_valid | text_stall | text_word (out_word_t)     | out
//
// the front end takes one raw word per cycle while the run queue has room
// each raw word yields 0 to 10 output words; the sequencer gives one per cycle
// while the text side is not stalled
// a queue of two runs plus the output register let the two sides stall apart
// reset is asynchronous and active low: plain text mode, queue and output empty
// no clearing pass: held hex digits are only read after being written in the run
module escaped_string_utf8_decoder_unit
    import esud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      raw_valid,
    output logic      raw_stall,
    input  in_word_t  raw_word,
    output logic      text_valid,
    input  logic      text_stall,
    output out_word_t text_word
);

    logic take;
    logic push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    run_t front_run;
    run_t head_run;

    // raw side stalls only on a full queue
    assign raw_stall = q_full;
    assign take      = raw_valid && !raw_stall;

    // runs with no bytes are dropped unless they close the string
    assign push = take && ((front_run.count != '0) || front_run.last);

    esud_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (raw_word),
        .run   (front_run)
    );

    esud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_run     (front_run),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_run   (head_run)
    );

    esud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_run   (head_run),
        .pop        (q_pop),
        .out_valid  (text_valid),
        .out_stall  (text_stall),
        .out_word   (text_word)
    );

endmodule
